@@ rtl/itdf_pkg.sv @@
// shared types, constants and arithmetic helpers for the transposed df2 iir filter
// no dependencies; used by the sequencer, datapath and top level
`timescale 1ns / 1ps
`default_nettype none

package itdf_pkg;

   // filter order, 1 or 2
   localparam int ORDER = 2;

   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 16;
   localparam int PROD_W   = SAMPLE_W + COEF_W;
   localparam int Z_W      = 40;
   localparam int ACC_W    = Z_W + 2;
   localparam int FRAC_SH  = 14;
   localparam int INDEX_W  = 3;
   localparam int PC_W     = 3;

   // last microprogram step for the chosen order
   localparam logic [PC_W-1:0] LAST_PC = (ORDER == 1) ? PC_W'(4) : PC_W'(5);

   typedef enum logic [INDEX_W-1:0] {
      REG_B0 = 3'd0,
      REG_B1 = 3'd1,
      REG_B2 = 3'd2,
      REG_A1 = 3'd3,
      REG_A2 = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] b0;
      logic signed [COEF_W-1:0] b1;
      logic signed [COEF_W-1:0] b2;
      logic signed [COEF_W-1:0] a1;
      logic signed [COEF_W-1:0] a2;
   } coef_type;

   typedef enum logic [2:0] {
      CSEL_B0 = 3'd0,
      CSEL_B1 = 3'd1,
      CSEL_B2 = 3'd2,
      CSEL_A1 = 3'd3,
      CSEL_A2 = 3'd4
   } coef_sel_type;

   typedef enum logic [1:0] {
      OPND_X_BUF  = 2'd0,
      OPND_X_WORK = 2'd1,
      OPND_YS     = 2'd2
   } opnd_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD    = 2'd0,
      ACC_Z0_PROD = 2'd1,
      ACC_Z1_PROD = 2'd2,
      ACC_PROD    = 2'd3
   } acc_op_type;

   typedef enum logic {
      Z0_HOLD     = 1'b0,
      Z0_SAT_DIFF = 1'b1
   } z0_op_type;

   typedef enum logic [1:0] {
      Z1_HOLD     = 2'd0,
      Z1_PROD     = 2'd1,
      Z1_SAT_DIFF = 2'd2,
      Z1_CLEAR    = 2'd3
   } z1_op_type;

   typedef enum logic [1:0] {
      COND_NONE = 2'd0,
      COND_IN   = 2'd1,
      COND_OUT  = 2'd2
   } cond_type;

   // one microcode word
   typedef struct packed {
      cond_type     cond;      // step waits on this condition
      logic         take_x;    // move buffered sample into the working register
      logic         mul_en;
      coef_sel_type coef_sel;
      opnd_sel_type opnd_sel;
      acc_op_type   acc_op;
      logic         ys_load;
      z0_op_type    z0_op;
      z1_op_type    z1_op;
      logic         push;      // hand ys to the output register
      logic         last;      // wrap to step 0
   } ctrl_word_type;

   // round half up by 14 bits, saturate to a 16-bit sample
   function automatic logic signed [SAMPLE_W-1:0] round_sat(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W:0]         t;
      logic signed [ACC_W-FRAC_SH:0] q;
      t = (ACC_W+1)'(v) + (ACC_W+1)'(1 <<< (FRAC_SH - 1));
      q = t[ACC_W:FRAC_SH];
      if (q > (ACC_W-FRAC_SH+1)'((1 <<< (SAMPLE_W - 1)) - 1)) begin
         round_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end else if (q < -(ACC_W-FRAC_SH+1)'(1 <<< (SAMPLE_W - 1))) begin
         round_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         round_sat = q[SAMPLE_W-1:0];
      end
   endfunction

   // saturate to the signed delay register range
   function automatic logic signed [Z_W-1:0] sat_z(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] zmax;
      logic signed [ACC_W-1:0] zmin;
      zmax = ACC_W'($signed({1'b0, {(Z_W-1){1'b1}}}));
      zmin = ACC_W'($signed({1'b1, {(Z_W-1){1'b0}}}));
      if (v > zmax) begin
         sat_z = {1'b0, {(Z_W-1){1'b1}}};
      end else if (v < zmin) begin
         sat_z = {1'b1, {(Z_W-1){1'b0}}};
      end else begin
         sat_z = v[Z_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

@@ rtl/itdf_sequencer.sv @@
// microcode sequencer: step counter, control store and wait conditions
// depends on itdf_pkg
`timescale 1ns / 1ps
`default_nettype none

module itdf_sequencer (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    x_full,    // a sample waits in the input buffer
   input  wire                    out_free,  // output register can take a result
   output itdf_pkg::ctrl_word_type ctrl,
   output logic                   step_go
);

   logic [itdf_pkg::PC_W-1:0] pc_ff;
   logic [itdf_pkg::PC_W-1:0] pc_in;

   // control store
   function automatic itdf_pkg::ctrl_word_type ucode(input logic [itdf_pkg::PC_W-1:0] pc);
      itdf_pkg::ctrl_word_type w;
      w = '0;
      case (pc)
         3'd0: begin
            w.cond     = itdf_pkg::COND_IN;
            w.take_x   = 1'b1;
            w.mul_en   = 1'b1;
            w.coef_sel = itdf_pkg::CSEL_B0;
            w.opnd_sel = itdf_pkg::OPND_X_BUF;
         end
         3'd1: begin
            w.acc_op   = itdf_pkg::ACC_Z0_PROD;
            w.mul_en   = 1'b1;
            w.coef_sel = itdf_pkg::CSEL_B1;
            w.opnd_sel = itdf_pkg::OPND_X_WORK;
         end
         3'd2: begin
            w.ys_load = 1'b1;
            if (itdf_pkg::ORDER == 1) begin
               w.acc_op = itdf_pkg::ACC_PROD;
            end else begin
               w.acc_op   = itdf_pkg::ACC_Z1_PROD;
               w.mul_en   = 1'b1;
               w.coef_sel = itdf_pkg::CSEL_B2;
               w.opnd_sel = itdf_pkg::OPND_X_WORK;
            end
         end
         3'd3: begin
            w.cond     = itdf_pkg::COND_OUT;
            w.push     = 1'b1;
            w.mul_en   = 1'b1;
            w.coef_sel = itdf_pkg::CSEL_A1;
            w.opnd_sel = itdf_pkg::OPND_YS;
            if (itdf_pkg::ORDER != 1) begin
               w.z1_op = itdf_pkg::Z1_PROD;
            end
         end
         3'd4: begin
            w.z0_op = itdf_pkg::Z0_SAT_DIFF;
            if (itdf_pkg::ORDER == 1) begin
               w.z1_op = itdf_pkg::Z1_CLEAR;
               w.last  = 1'b1;
            end else begin
               w.mul_en   = 1'b1;
               w.coef_sel = itdf_pkg::CSEL_A2;
               w.opnd_sel = itdf_pkg::OPND_YS;
            end
         end
         3'd5: begin
            w.z1_op = itdf_pkg::Z1_SAT_DIFF;
            w.last  = 1'b1;
         end
         default: begin
            w.last = 1'b1;
         end
      endcase
      return w;
   endfunction

   always_comb begin
      ctrl = ucode(pc_ff);
      case (ctrl.cond)
         itdf_pkg::COND_IN:  step_go = x_full;
         itdf_pkg::COND_OUT: step_go = out_free;
         default:            step_go = 1'b1;
      endcase
      if (!step_go) begin
         pc_in = pc_ff;
      end else if (ctrl.last) begin
         pc_in = '0;
      end else begin
         pc_in = pc_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0;
      end else begin
         pc_ff <= pc_in;
      end
   end

`ifndef SYNTHESIS
   a_pc_in_program: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= itdf_pkg::LAST_PC)
      else $error("step counter left the program");
   a_wrap_on_last: assert property (@(posedge clock) disable iff (reset)
      ctrl.last && step_go |=> pc_ff == '0)
      else $error("sequencer did not wrap after the last step");
`endif

endmodule

`default_nettype wire

@@ rtl/itdf_datapath.sv @@
// datapath: shared 16x16 multiplier, accumulator, output rounding and delay registers
// depends on itdf_pkg; driven by the sequencer control word
`timescale 1ns / 1ps
`default_nettype none

module itdf_datapath (
   input  wire                                      clock,
   input  wire                                      reset,
   input  itdf_pkg::ctrl_word_type                  ctrl,
   input  wire                                      step_go,
   input  itdf_pkg::coef_type                       coef,
   input  wire signed [itdf_pkg::SAMPLE_W-1:0]      x_buf,
   output logic signed [itdf_pkg::SAMPLE_W-1:0]     ys
);

   logic signed [itdf_pkg::SAMPLE_W-1:0] x_work_ff, x_work_in;
   logic signed [itdf_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic signed [itdf_pkg::ACC_W-1:0]    acc_ff, acc_in;
   logic signed [itdf_pkg::SAMPLE_W-1:0] ys_ff, ys_in;
   logic signed [itdf_pkg::Z_W-1:0]      z0_ff, z0_in;
   logic signed [itdf_pkg::Z_W-1:0]      z1_ff, z1_in;
   logic signed [itdf_pkg::COEF_W-1:0]   mul_coef;
   logic signed [itdf_pkg::SAMPLE_W-1:0] mul_opnd;
   logic signed [itdf_pkg::ACC_W-1:0]    prod_ext;

   assign ys       = ys_ff;
   assign prod_ext = itdf_pkg::ACC_W'(prod_ff);

   always_comb begin
      case (ctrl.coef_sel)
         itdf_pkg::CSEL_B0: mul_coef = coef.b0;
         itdf_pkg::CSEL_B1: mul_coef = coef.b1;
         itdf_pkg::CSEL_B2: mul_coef = coef.b2;
         itdf_pkg::CSEL_A1: mul_coef = coef.a1;
         itdf_pkg::CSEL_A2: mul_coef = coef.a2;
         default:           mul_coef = coef.b0;
      endcase
      case (ctrl.opnd_sel)
         itdf_pkg::OPND_X_BUF:  mul_opnd = x_buf;
         itdf_pkg::OPND_X_WORK: mul_opnd = x_work_ff;
         itdf_pkg::OPND_YS:     mul_opnd = ys_ff;
         default:               mul_opnd = x_work_ff;
      endcase

      x_work_in = x_work_ff;
      prod_in   = prod_ff;
      acc_in    = acc_ff;
      ys_in     = ys_ff;
      z0_in     = z0_ff;
      z1_in     = z1_ff;

      if (step_go) begin
         if (ctrl.take_x) begin
            x_work_in = x_buf;
         end
         if (ctrl.mul_en) begin
            prod_in = mul_coef * mul_opnd;
         end
         case (ctrl.acc_op)
            itdf_pkg::ACC_Z0_PROD: acc_in = itdf_pkg::ACC_W'(z0_ff) + prod_ext;
            itdf_pkg::ACC_Z1_PROD: acc_in = itdf_pkg::ACC_W'(z1_ff) + prod_ext;
            itdf_pkg::ACC_PROD:    acc_in = prod_ext;
            default:               acc_in = acc_ff;
         endcase
         if (ctrl.ys_load) begin
            ys_in = itdf_pkg::round_sat(acc_ff);
         end
         if (ctrl.z0_op == itdf_pkg::Z0_SAT_DIFF) begin
            z0_in = itdf_pkg::sat_z(acc_ff - prod_ext);
         end
         case (ctrl.z1_op)
            itdf_pkg::Z1_PROD:     z1_in = itdf_pkg::Z_W'(prod_ff);
            itdf_pkg::Z1_SAT_DIFF: z1_in = itdf_pkg::sat_z(itdf_pkg::ACC_W'(z1_ff) - prod_ext);
            itdf_pkg::Z1_CLEAR:    z1_in = '0;
            default:               z1_in = z1_ff;
         endcase
      end
   end

   // working registers carry no reset
   always_ff @(posedge clock) begin
      x_work_ff <= x_work_in;
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      ys_ff     <= ys_in;
   end

   // filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         z0_ff <= '0;
         z1_ff <= '0;
      end else begin
         z0_ff <= z0_in;
         z1_ff <= z1_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/iir_transposed_df2_filter_unit.sv @@
// top level of the transposed direct form ii iir filter (order 1 or 2)
// depends on itdf_pkg, itdf_sequencer and itdf_datapath
`timescale 1ns / 1ps
`default_nettype none

// channel  | direction | handshake             | payload
// ---------+-----------+-----------------------+---------------------------------
// req      | in        | req_tvalid/req_tready | req_tdata: sample_in, q1.15
// rsp      | out       | rsp_tvalid/rsp_tready | rsp_tdata: sample_out, q1.15
// csr      | in        | csr_valid/csr_ready   | csr_index, csr_data: q2.14 coef
//
// each sample is worked through the one shared 16x16 multiplier, which the
// microprogram walks through b0, b1, a1 and, at order 2 only, b2 and a2
// the result beat is loaded into the output register at step 3 of the program
// a one-deep input buffer takes the next beat while the current sample is worked
// the program holds at step 3 while an earlier result still waits on rsp_tready
// reset is synchronous; coefficients and delay state reset at once

module iir_transposed_df2_filter_unit (
   input  wire                                  clock,
   input  wire                                  reset,
   // input samples
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   input  wire  [itdf_pkg::SAMPLE_W-1:0]        req_tdata,   // [15:0] sample_in
   // filtered samples
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic [itdf_pkg::SAMPLE_W-1:0]        rsp_tdata,   // [15:0] sample_out
   // coefficient writes
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [itdf_pkg::INDEX_W-1:0]         csr_index,
   input  wire  [itdf_pkg::COEF_W-1:0]          csr_data
);

   // coefficient registers
   itdf_pkg::coef_type coef_ff, coef_in;

   // input buffer
   logic signed [itdf_pkg::SAMPLE_W-1:0] x_buf_ff, x_buf_in;
   logic                                 x_full_ff, x_full_in;

   // output register
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [itdf_pkg::SAMPLE_W-1:0]        rsp_data_ff, rsp_data_in;

   itdf_pkg::ctrl_word_type              ctrl;
   logic                                 step_go;
   logic                                 out_free;
   logic signed [itdf_pkg::SAMPLE_W-1:0] ys;
   logic                                 req_beat;

   assign req_tready = !x_full_ff;
   assign req_beat   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   // the output register frees up in the same cycle its beat is taken
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      coef_in = coef_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            itdf_pkg::REG_B0: coef_in.b0 = csr_data;
            itdf_pkg::REG_B1: coef_in.b1 = csr_data;
            itdf_pkg::REG_B2: coef_in.b2 = csr_data;
            itdf_pkg::REG_A1: coef_in.a1 = csr_data;
            itdf_pkg::REG_A2: coef_in.a2 = csr_data;
            default:          coef_in = coef_ff;  // writes past the list are dropped
         endcase
      end

      x_buf_in  = x_buf_ff;
      x_full_in = x_full_ff;
      if (req_beat) begin
         x_buf_in  = req_tdata;
         x_full_in = 1'b1;
      end else if (ctrl.take_x && step_go) begin
         x_full_in = 1'b0;
      end

      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.push && step_go) begin
         rsp_data_in  = ys;
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.b0   <= 16'sd16384;  // unity gain passthrough
         coef_ff.b1   <= '0;
         coef_ff.b2   <= '0;
         coef_ff.a1   <= '0;
         coef_ff.a2   <= '0;
         x_full_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         coef_ff      <= coef_in;
         x_full_ff    <= x_full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_buf_ff    <= x_buf_in;
      rsp_data_ff <= rsp_data_in;
   end

   itdf_sequencer u_sequencer (
      .clock    (clock),
      .reset    (reset),
      .x_full   (x_full_ff),
      .out_free (out_free),
      .ctrl     (ctrl),
      .step_go  (step_go)
   );

   itdf_datapath u_datapath (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ctrl),
      .step_go (step_go),
      .coef    (coef_ff),
      .x_buf   (x_buf_ff),
      .ys      (ys)
   );

`ifndef SYNTHESIS
   a_take_needs_sample: assert property (@(posedge clock) disable iff (reset)
      ctrl.take_x && step_go |-> x_full_ff)
      else $error("program consumed an empty input buffer");
   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      ctrl.push && step_go |-> !rsp_valid_ff || rsp_tready)
      else $error("result overwrote a beat not yet taken");
   a_rsp_from_push: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctrl.push && step_go))
      else $error("result beat appeared without a push step");
`endif

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// self-checking testbench for iir_transposed_df2_filter_unit: directed table, then random traffic
// depends on rtl/itdf_pkg.sv and rtl/iir_transposed_df2_filter_unit.sv
`timescale 1ns / 1ps

module tb_top;
   import itdf_pkg::*;

   // csr indexes past the last coefficient, writes there must be dropped
   localparam logic [INDEX_W-1:0] IDX_SPARE_LO = 3'd5;
   localparam logic [INDEX_W-1:0] IDX_SPARE_HI = 3'd7;

   // settle time after the last owed output, to let the tail of the filter finish
   localparam int SETTLE_CYCLES = 16;
   localparam int RAND_SETS     = 2;    // coefficient sets per idle phase
   localparam int SET_SAMPLES   = 170;  // samples per coefficient set

   typedef enum bit {ROW_SAMPLE, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      logic [INDEX_W-1:0]   index;   // register index on write rows
      logic [COEF_W-1:0]    value;   // coefficient or input sample
      bit                   typed;   // want is filled in by hand
      logic [SAMPLE_W-1:0]  want;
   } stim_row_type;

   localparam int DIR_ROWS = 25;

   // directed rows; hex values are two's complement
   stim_row_type dir_table [DIR_ROWS] = '{
      // reset coefficients give a straight pass-through
      '{ROW_SAMPLE, REG_B0,       16'h0000, 1'b1, 16'h0000},
      '{ROW_SAMPLE, REG_B0,       16'h7FFF, 1'b1, 16'h7FFF},
      '{ROW_SAMPLE, REG_B0,       16'h8000, 1'b1, 16'h8000},
      '{ROW_SAMPLE, REG_B0,       16'h0001, 1'b1, 16'h0001},
      '{ROW_SAMPLE, REG_B0,       16'hFFFF, 1'b1, 16'hFFFF},
      // writes past the last register leave the filter untouched
      '{ROW_WRITE,  IDX_SPARE_LO, 16'h8000, 1'b0, 16'h0000},
      '{ROW_WRITE,  IDX_SPARE_HI, 16'h7FFF, 1'b0, 16'h0000},
      '{ROW_SAMPLE, REG_B0,       16'h04D2, 1'b1, 16'h04D2},
      // b0 = -2.0: output saturates both ways
      '{ROW_WRITE,  REG_B0,       16'h8000, 1'b0, 16'h0000},
      '{ROW_SAMPLE, REG_B0,       16'h8000, 1'b1, 16'h7FFF},
      '{ROW_SAMPLE, REG_B0,       16'h7FFF, 1'b1, 16'h8000},
      // b0 just under 2.0
      '{ROW_WRITE,  REG_B0,       16'h7FFF, 1'b0, 16'h0000},
      '{ROW_SAMPLE, REG_B0,       16'h7FFF, 1'b1, 16'h7FFF},
      // smallest b0: exact halves round toward plus infinity
      '{ROW_WRITE,  REG_B0,       16'h0001, 1'b0, 16'h0000},
      '{ROW_SAMPLE, REG_B0,       16'h2000, 1'b1, 16'h0001},
      '{ROW_SAMPLE, REG_B0,       16'hE000, 1'b1, 16'h0000},
      '{ROW_SAMPLE, REG_B0,       16'hDFFF, 1'b1, 16'hFFFF},
      // extreme feedforward and feedback terms, predicted
      '{ROW_WRITE,  REG_B1,       16'h8000, 1'b0, 16'h0000},
      '{ROW_WRITE,  REG_B2,       16'h7FFF, 1'b0, 16'h0000},
      '{ROW_WRITE,  REG_A1,       16'h8000, 1'b0, 16'h0000},
      '{ROW_WRITE,  REG_A2,       16'h7FFF, 1'b0, 16'h0000},
      '{ROW_SAMPLE, REG_B0,       16'h7FFF, 1'b0, 16'h0000},
      '{ROW_SAMPLE, REG_B0,       16'h8000, 1'b0, 16'h0000},
      '{ROW_SAMPLE, REG_B0,       16'h4E20, 1'b0, 16'h0000},
      '{ROW_SAMPLE, REG_B0,       16'hFFFF, 1'b0, 16'h0000}
   };

   // dut ports, all driven from time zero
   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [SAMPLE_W-1:0]  req_tdata  = '0;     // [15:0] sample_in
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [SAMPLE_W-1:0]  rsp_tdata;           // [15:0] sample_out
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [INDEX_W-1:0]   csr_index  = '0;
   logic [COEF_W-1:0]    csr_data   = '0;

   // idle rates in percent, changed per phase
   int unsigned req_gap_pct   = 0;
   int unsigned rsp_stall_pct = 0;

   // filter shadow: coefficients and q11.29 delay line
   logic signed [COEF_W-1:0] coef_regs [5];
   longint                   delay_line [2];

   // filtered samples still owed by the dut, oldest first
   logic [SAMPLE_W-1:0] owed_outputs [$];
   int unsigned         error_count = 0;
   int unsigned         beat_count  = 0;

   iir_transposed_df2_filter_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      error_count++;
   endtask

   // clamp to the signed 40-bit delay range
   function automatic longint clamp_delay(input longint v);
      longint zmax;
      longint zmin;
      zmax = (longint'(1) <<< 39) - 1;
      zmin = -(longint'(1) <<< 39);
      if (v > zmax) begin
         return zmax;
      end else if (v < zmin) begin
         return zmin;
      end
      return v;
   endfunction

   // one step of the filter: returns the q1.15 output and advances the delay line
   function automatic logic [SAMPLE_W-1:0] filter_sample(input logic signed [SAMPLE_W-1:0] x);
      longint xs;
      longint acc;
      longint ys;
      longint b0;
      longint b1;
      longint b2;
      longint a1;
      longint a2;
      xs  = x;
      b0  = coef_regs[REG_B0];
      b1  = coef_regs[REG_B1];
      b2  = coef_regs[REG_B2];
      a1  = coef_regs[REG_A1];
      a2  = coef_regs[REG_A2];
      acc = delay_line[0] + b0 * xs;
      // floor shift after adding half an lsb rounds half up
      ys  = (acc + 8192) >>> FRAC_SH;
      if (ys > 32767) begin
         ys = 32767;
      end else if (ys < -32768) begin
         ys = -32768;
      end
      // feedback takes the rounded, saturated output
      if (ORDER == 1) begin
         delay_line[0] = clamp_delay(b1 * xs - a1 * ys);
         delay_line[1] = 0;
      end else begin
         delay_line[0] = clamp_delay(delay_line[1] - a1 * ys + b1 * xs);
         delay_line[1] = clamp_delay(b2 * xs - a2 * ys);
      end
      return ys[SAMPLE_W-1:0];
   endfunction

   // one coefficient write beat, then the write channel goes quiet
   task automatic write_coef(input logic [INDEX_W-1:0] idx, input logic [COEF_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx <= REG_A2) begin
         coef_regs[idx] = val;
      end
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // one input beat with random idle cycles ahead of it
   task automatic send_sample(input logic [SAMPLE_W-1:0] x, input bit typed,
                              input logic [SAMPLE_W-1:0] want);
      logic [SAMPLE_W-1:0] predicted;
      while ($urandom_range(0, 99) < req_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= x;
      do @(posedge clock); while (!req_tready);
      // beat taken at this edge
      predicted = filter_sample(x);
      owed_outputs.push_back(typed ? want : predicted);
   endtask

   // stop sending, let every owed output arrive and the delay update finish
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (owed_outputs.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // coefficient mix: extremes, zero, small stable-ish values, anything
   function automatic logic [COEF_W-1:0] pick_coef();
      case ($urandom_range(0, 6))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return COEF_W'($signed($urandom_range(0, 8192)) - 4096);
         default: return COEF_W'($urandom);
      endcase
   endfunction

   // sample mix: mostly full range, some extremes and small values
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return SAMPLE_W'($signed($urandom_range(0, 64)) - 32);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // output side: random back-pressure, check every result beat against the oldest owed output
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         beat_count++;
         if (owed_outputs.size() == 0) begin
            report_mismatch($sformatf("result beat %0d with no sample owed", beat_count));
         end else begin
            logic [SAMPLE_W-1:0] want;
            want = owed_outputs.pop_front();
            if (rsp_tdata !== want) begin
               report_mismatch($sformatf("beat %0d sample_out got %0d want %0d", beat_count,
                                         $signed(rsp_tdata), $signed(want)));
            end
         end
      end
   end

   // stimulus: reset, directed table, then random traffic in three idle phases
   initial begin
      coef_regs[REG_B0] = 16'h4000;  // 1.0
      coef_regs[REG_B1] = '0;
      coef_regs[REG_B2] = '0;
      coef_regs[REG_A1] = '0;
      coef_regs[REG_A2] = '0;
      delay_line[0]     = 0;
      delay_line[1]     = 0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows run with no idling; writes only once the filter is quiet
      for (int r = 0; r < DIR_ROWS; r++) begin
         if (dir_table[r].kind == ROW_WRITE) begin
            if (r == 0 || dir_table[r-1].kind != ROW_WRITE) begin
               wait_drained();
            end
            write_coef(dir_table[r].index, dir_table[r].value);
         end else begin
            send_sample(dir_table[r].value, dir_table[r].typed, dir_table[r].want);
         end
      end

      // phase 0: sender idles lightly, receiver heavily; phase 1 swapped; phase 2 flat out
      for (int phase = 0; phase < 3; phase++) begin
         for (int set = 0; set < RAND_SETS; set++) begin
            wait_drained();
            req_gap_pct   = (phase == 0) ? 19 : (phase == 1) ? 88 : 0;
            rsp_stall_pct = (phase == 0) ? 88 : (phase == 1) ? 19 : 0;
            write_coef(REG_B0, pick_coef());
            write_coef(REG_B1, pick_coef());
            write_coef(REG_B2, pick_coef());
            write_coef(REG_A1, pick_coef());
            write_coef(REG_A2, pick_coef());
            if ($urandom_range(0, 1) == 1) begin
               write_coef(IDX_SPARE_LO + INDEX_W'($urandom_range(0, 2)), COEF_W'($urandom));
            end
            for (int n = 0; n < SET_SAMPLES; n++) begin
               // now and then hold off until the pipe is empty
               if ($urandom_range(0, 49) == 0) begin
                  wait_drained();
               end
               send_sample(pick_sample(), 1'b0, '0);
            end
         end
      end

      wait_drained();
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // watchdog, far past the slowest legal run
   initial begin
      #5ms;
      $display("Regression FAIL");
      $finish;
   end

endmodule
